// ===== src/command_line_assembler_echo_defines.svh =====
// assertion macros for the command line assembler with echo
// used by the top level only; expects clk and rst_n in scope
`ifndef COMMAND_LINE_ASSEMBLER_ECHO_DEFINES_SVH
`define COMMAND_LINE_ASSEMBLER_ECHO_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cla check failed");

// next-cycle implication, checked outside reset
`define CLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cla check failed");

`endif

// ===== src/cla_pkg.sv =====
// shared types and constants for the command line assembler with echo
// no dependencies
package cla_pkg;

  // line store geometry
  localparam int LINE_SIZE = 32;
  localparam int CNT_W     = $clog2(LINE_SIZE);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(LINE_SIZE - 1);

  // character codes
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DATA = 4'b0010,
    S_LF   = 4'b0100,
    S_CR   = 4'b1000
  } seq_state_t;

  // write request into the line store
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } line_wr_t;

endpackage

// ===== src/cla_line_buf.sv =====
// line store: one write port, one registered read port
// depends on cla_pkg
module cla_line_buf (
  input  logic                     clk,
  input  cla_pkg::line_wr_t        wr,
  input  logic [cla_pkg::CNT_W-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [cla_pkg::LINE_SIZE];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/cla_echo_seq.sv =====
// sequencer: collects printable bytes into the line store and replays it on enter
// depends on cla_pkg; drives the read address of cla_line_buf
module cla_echo_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,
  output logic                      out_tlast,
  output cla_pkg::line_wr_t         wr,
  output logic [cla_pkg::CNT_W-1:0] rd_addr,
  input  logic [7:0]                rd_data
);

  cla_pkg::seq_state_t        state_r, state_nxt;
  logic [cla_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [cla_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [cla_pkg::CNT_W-1:0]  idx_inc;
  logic                       printable;

  assign printable = (in_tdata >= cla_pkg::CH_PRINT_LO) && (in_tdata <= cla_pkg::CH_PRINT_HI);
  assign idx_inc   = idx_r + 1'b1;

  // next state, count and replay index
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    wr        = '0;
    case (state_r)
      cla_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (printable) begin
            wr.en   = 1'b1;
            wr.addr = count_r;
            wr.data = in_tdata;
            count_nxt = (count_r == cla_pkg::LAST_IDX) ? '0 : count_r + 1'b1;
          end else if (in_tdata == cla_pkg::CH_ESC) begin
            count_nxt = '0;
          end else if (in_tdata == cla_pkg::CH_CR) begin
            idx_nxt   = '0;
            state_nxt = (count_r == '0) ? cla_pkg::S_LF : cla_pkg::S_DATA;
          end
        end
      end
      cla_pkg::S_DATA: begin
        if (out_tready) begin
          if (idx_inc == count_r) begin
            state_nxt = cla_pkg::S_LF;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      cla_pkg::S_LF: begin
        if (out_tready) begin
          state_nxt = cla_pkg::S_CR;
        end
      end
      cla_pkg::S_CR: begin
        if (out_tready) begin
          state_nxt = cla_pkg::S_IDLE;
          count_nxt = '0;
        end
      end
      default: begin
        state_nxt = cla_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cla_pkg::S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // read ahead so the store data lines up with idx_r
  assign rd_addr = idx_nxt;

  // handshake and result mux
  assign in_tready  = (state_r == cla_pkg::S_IDLE);
  assign out_tvalid = (state_r == cla_pkg::S_DATA) || (state_r == cla_pkg::S_LF) ||
                      (state_r == cla_pkg::S_CR);
  assign out_tlast  = (state_r == cla_pkg::S_CR);

  always_comb begin
    case (state_r)
      cla_pkg::S_DATA: out_tdata = rd_data;
      cla_pkg::S_LF:   out_tdata = cla_pkg::CH_LF;
      cla_pkg::S_CR:   out_tdata = cla_pkg::CH_CR;
      default:         out_tdata = '0;
    endcase
  end

endmodule

// ===== src/command_line_assembler_echo.sv =====
// command line assembler with echo, top level; depends on cla_pkg, cla_line_buf, cla_echo_seq
// non-enter bytes are taken back to back while idle; the first result of an enter is valid
// the next cycle, then one result per cycle while out_tready is high
// after an enter, in_tready stays low until the stored bytes, LF and CR have been sent
// reset (rst_n low, synchronous) empties the line; stored bytes are not cleared
`include "command_line_assembler_echo_defines.svh"

module command_line_assembler_echo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast
);

  cla_pkg::line_wr_t          wr;
  logic [cla_pkg::CNT_W-1:0]  rd_addr;
  logic [7:0]                 rd_data;

  // sequencer
  cla_echo_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // line store
  cla_line_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // checks
  `CLA_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid)
  `CLA_ASSERT_NOW(a_last_is_cr, out_tvalid && out_tlast, out_tdata == cla_pkg::CH_CR)
  `CLA_ASSERT_NEXT(a_cr_starts_echo, in_tvalid && in_tready && in_tdata == cla_pkg::CH_CR, out_tvalid)
  `CLA_ASSERT_NEXT(a_last_frees_input, out_tvalid && out_tready && out_tlast, in_tready)

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the command line assembler with echo
// drives received bytes on the in_ stream and checks every echoed byte on the out_ stream
// depends on cla_pkg and the command_line_assembler_echo top level
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  // one echoed byte as the block should send it
  typedef struct packed {
    logic [7:0] tx;
    logic       fin;
  } echo_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] rx_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] tx_byte
  logic       out_tlast;

  // shadow copy of the line and its write count
  logic [7:0]                line_shadow [cla_pkg::LINE_SIZE];
  logic [cla_pkg::CNT_W-1:0] line_len_shadow;
  echo_byte_t                echo_expect_q [$];
  echo_byte_t                echo_head;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  command_line_assembler_echo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h expected %02h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // update the shadow line for one accepted byte and queue the echo it causes
  task automatic predict_echo(input logic [7:0] rx);
    if (rx >= cla_pkg::CH_PRINT_LO && rx <= cla_pkg::CH_PRINT_HI) begin
      line_shadow[line_len_shadow] = rx;
      line_len_shadow = line_len_shadow + 1'b1;
    end else if (rx == cla_pkg::CH_ESC) begin
      line_len_shadow = '0;
    end else if (rx == cla_pkg::CH_CR) begin
      for (int i = 0; i < int'(line_len_shadow); i++)
        echo_expect_q.push_back('{tx: line_shadow[i], fin: 1'b0});
      echo_expect_q.push_back('{tx: cla_pkg::CH_LF, fin: 1'b0});
      echo_expect_q.push_back('{tx: cla_pkg::CH_CR, fin: 1'b1});
      line_len_shadow = '0;
    end
  endtask

  // one input transaction, with a random gap in front
  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    do @(posedge clk); while (!in_tready);
    predict_echo(rx);
  endtask

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(int'(cla_pkg::CH_PRINT_HI), int'(cla_pkg::CH_PRINT_LO)));
  endfunction

  // edge bytes, empty line, escape, ignored control and high bytes
  task automatic test_directed();
    send_byte(cla_pkg::CH_CR);
    send_byte(cla_pkg::CH_PRINT_LO);
    send_byte(cla_pkg::CH_PRINT_HI);
    send_byte(8'h41);
    send_byte(cla_pkg::CH_CR);
    send_byte(8'h30);
    send_byte(8'h31);
    send_byte(cla_pkg::CH_ESC);
    send_byte(8'h32);
    send_byte(cla_pkg::CH_CR);
    send_byte(8'h61);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h1F);
    send_byte(cla_pkg::CH_LF);
    send_byte(8'h0C);
    send_byte(8'h0E);
    send_byte(8'h62);
    send_byte(cla_pkg::CH_CR);
  endtask

  // lines that fill the store and wrap the count
  task automatic test_line_wrap(input int n_lines);
    int len;
    for (int l = 0; l < n_lines; l++) begin
      len = (l == 0) ? cla_pkg::LINE_SIZE
                     : $urandom_range(cla_pkg::LINE_SIZE + 8, cla_pkg::LINE_SIZE - 2);
      for (int i = 0; i < len; i++)
        send_byte(rand_printable());
      send_byte(cla_pkg::CH_CR);
    end
  endtask

  // mostly well formed lines, some noise, escapes and broken lines
  task automatic test_random_lines(input int n_items);
    int sent;
    int len;
    int pick;
    logic [7:0] noise;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        noise = 8'($urandom_range(255));
        send_byte(noise);
        if (noise == cla_pkg::CH_ESC || noise == cla_pkg::CH_CR ||
            (noise >= cla_pkg::CH_PRINT_LO && noise <= cla_pkg::CH_PRINT_HI))
          sent++;
      end else if (pick < 13) begin
        send_byte(cla_pkg::CH_ESC);
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(cla_pkg::LINE_SIZE + 4, 20)
                                       : $urandom_range(8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0)
            send_byte(8'($urandom_range(255, 8'h7F)));
          send_byte(rand_printable());
          sent++;
        end
        // a broken line is dropped by escape instead of ended by enter
        send_byte(($urandom_range(9) == 0) ? cla_pkg::CH_ESC : cla_pkg::CH_CR);
        sent++;
      end
    end
  endtask

  // output checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (echo_expect_q.size() == 0) begin
        report_mismatch("unexpected tx_byte", out_tdata, 8'h00);
      end else begin
        echo_head = echo_expect_q.pop_front();
        if (out_tdata !== echo_head.tx)
          report_mismatch("tx_byte", out_tdata, echo_head.tx);
        if (out_tlast !== echo_head.fin)
          report_mismatch("last", {7'd0, out_tlast}, {7'd0, echo_head.fin});
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < cla_pkg::LINE_SIZE; i++)
      line_shadow[i] = 8'h00;
    line_len_shadow = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_directed();
    test_line_wrap(2);
    test_random_lines(50);

    send_idle_pct = 87;
    recv_stall_pct = 0;
    test_random_lines(45);

    send_idle_pct = 0;
    recv_stall_pct = 87;
    test_random_lines(45);
    test_line_wrap(1);

    send_idle_pct = 28;
    recv_stall_pct = 28;
    test_random_lines(45);

    in_tvalid <= 1'b0;
    wait (echo_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && echo_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== command_line_assembler_echo.f =====
+incdir+src
src/cla_pkg.sv
src/cla_line_buf.sv
src/cla_echo_seq.sv
src/command_line_assembler_echo.sv
tb/tb_top.sv
